// ===== design/hfe_pkg.sv =====
// Shared widths, register indexes and divider request type for the haptic fade envelope.
`timescale 1ns / 1ps

package hfe_pkg;

  localparam int TIME_WIDTH  = 16;
  localparam int LEVEL_WIDTH = 16;

  localparam int ELAPSED_WIDTH = TIME_WIDTH + 1;
  localparam int PROD_WIDTH    = LEVEL_WIDTH + TIME_WIDTH;
  localparam int CFG_WIDTH     = (TIME_WIDTH > LEVEL_WIDTH) ? TIME_WIDTH : LEVEL_WIDTH;
  localparam int CFG_IDX_WIDTH = 3;
  localparam int IN_TDATA_WIDTH  = ((TIME_WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_WIDTH = ((LEVEL_WIDTH + 7) / 8) * 8;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_EFFECT_MODE    = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_TOTAL_DURATION = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_PEAK_LEVEL     = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_FADE_IN_TIME   = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_FADE_OUT_TIME  = 3'd4;

  localparam logic [TIME_WIDTH-1:0]  DURATION_RESET = TIME_WIDTH'(1000);
  localparam logic [LEVEL_WIDTH-1:0] PEAK_RESET     = {LEVEL_WIDTH{1'b1}};
  localparam logic [ELAPSED_WIDTH-1:0] ELAPSED_MAX  = {ELAPSED_WIDTH{1'b1}};

  typedef struct packed {
    logic                   start;
    logic [PROD_WIDTH-1:0]  dividend;
    logic [TIME_WIDTH-1:0]  divisor;
  } hfe_div_req_t;

endpackage

// ===== design/hfe_div.sv =====
// Restoring divider, one quotient bit per cycle; quotient must fit LEVEL_WIDTH bits.
`timescale 1ns / 1ps

module hfe_div
  import hfe_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  hfe_div_req_t           req,
  output logic                   done,
  output logic [LEVEL_WIDTH-1:0] quotient
);

  localparam int CNT_WIDTH = (LEVEL_WIDTH > 1) ? $clog2(LEVEL_WIDTH) : 1;

  logic [TIME_WIDTH-1:0]  rem;
  logic [LEVEL_WIDTH-1:0] low;
  logic [TIME_WIDTH-1:0]  divisor;
  logic [CNT_WIDTH-1:0]   cnt;
  logic                   busy;

  logic [TIME_WIDTH:0] trial;
  logic [TIME_WIDTH:0] diff;
  logic                fits;

  assign trial = {rem, low[LEVEL_WIDTH-1]};
  assign diff  = trial - {1'b0, divisor};
  assign fits  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy    <= 1'b1;
        cnt     <= CNT_WIDTH'(LEVEL_WIDTH - 1);
        rem     <= req.dividend[PROD_WIDTH-1:LEVEL_WIDTH];
        low     <= req.dividend[LEVEL_WIDTH-1:0];
        divisor <= req.divisor;
      end else if (busy) begin
        rem <= fits ? diff[TIME_WIDTH-1:0] : trial[TIME_WIDTH-1:0];
        low <= {low[LEVEL_WIDTH-2:0], fits};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = low;

endmodule

// ===== design/haptic_fade_envelope.sv =====
// Haptic fade envelope top level: config registers, sequencer, multiplier, divider and output register.
//
// Usage:
//   cfg channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes one of five registers:
//   0 effect mode, 1 total duration, 2 peak level, 3 fade-in time, 4 fade-out time.
//   Any write to a listed register arms the effect and clears elapsed time and level;
//   writes to other indexes are dropped. cfg_ready is high only while no tick is in work,
//   and a pending write holds s_tready low.
//   s_* carries one tick item: time_delta in s_tdata. Each tick yields one result item
//   on m_*: drive_level in m_tdata, effect_active in m_tuser.
//   A tick passes through EVAL and OUT when no ramp division is needed, and
//   through EVAL, MUL, LOAD, DIV and OUT through a fade ramp; the restoring
//   divider, one quotient bit per cycle, works while in DIV. One tick is in flight
//   at a time; s_tready is low while it is worked on, so a new tick is taken
//   only once the last one has left OUT.
//   The result sits in an output register; a new tick is taken while it waits.
//   If m_tready stays low, the next result holds inside until the register frees.
//   Reset: idle, not armed, level 0, registers at 0, 1000, full scale, 0, 0.
`timescale 1ns / 1ps

module haptic_fade_envelope
  import hfe_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_IDX_WIDTH-1:0]   cfg_index,
  input  logic [CFG_WIDTH-1:0]       cfg_data,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [IN_TDATA_WIDTH-1:0]  s_tdata,   // [TIME_WIDTH-1:0] time_delta
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [OUT_TDATA_WIDTH-1:0] m_tdata,   // [LEVEL_WIDTH-1:0] drive_level
  output logic [0:0]                 m_tuser    // [0] effect_active
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL,
    ST_LOAD,
    ST_DIV,
    ST_OUT
  } state_t;

  state_t state;

  logic                     effect_mode;
  logic [TIME_WIDTH-1:0]    total_duration;
  logic [LEVEL_WIDTH-1:0]   peak_level;
  logic [TIME_WIDTH-1:0]    fade_in_time;
  logic [TIME_WIDTH-1:0]    fade_out_time;

  logic [ELAPSED_WIDTH-1:0] elapsed_time;
  logic                     armed;
  logic [LEVEL_WIDTH-1:0]   current_level;

  logic [TIME_WIDTH-1:0]    num;
  logic [TIME_WIDTH-1:0]    den;
  logic [PROD_WIDTH-1:0]    product;

  logic [LEVEL_WIDTH-1:0]   out_level;
  logic                     out_active;
  logic                     out_valid;
  logic                     out_load;

  logic                     cfg_hit;
  logic                     in_fire;
  logic [ELAPSED_WIDTH:0]   sum;
  logic [ELAPSED_WIDTH-1:0] elapsed_next;
  logic [TIME_WIDTH-1:0]    remaining;
  logic                     in_fade_in;
  logic                     in_fade_out;

  hfe_div_req_t             div_req;
  logic                     div_done;
  logic [LEVEL_WIDTH-1:0]   div_quot;

  assign cfg_ready = (state == ST_IDLE);
  assign s_tready  = (state == ST_IDLE) && !cfg_valid;
  assign in_fire   = s_tvalid && s_tready;
  assign out_load  = (state == ST_OUT) && (!out_valid || m_tready);

  always_comb begin
    unique case (cfg_index)
      CFG_EFFECT_MODE, CFG_TOTAL_DURATION, CFG_PEAK_LEVEL,
      CFG_FADE_IN_TIME, CFG_FADE_OUT_TIME: cfg_hit = cfg_valid && cfg_ready;
      default:                             cfg_hit = 1'b0;
    endcase
  end

  assign sum          = {1'b0, elapsed_time} + (ELAPSED_WIDTH + 1)'(s_tdata[TIME_WIDTH-1:0]);
  assign elapsed_next = sum[ELAPSED_WIDTH] ? ELAPSED_MAX : sum[ELAPSED_WIDTH-1:0];

  assign remaining   = total_duration - elapsed_time[TIME_WIDTH-1:0];
  assign in_fade_in  = ({1'b0, fade_in_time} > elapsed_time);
  assign in_fade_out = (fade_out_time >= remaining) && (fade_out_time != '0);

  assign div_req.start    = (state == ST_LOAD);
  assign div_req.dividend = product;
  assign div_req.divisor  = den;

  hfe_div u_div (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      effect_mode    <= 1'b0;
      total_duration <= DURATION_RESET;
      peak_level     <= PEAK_RESET;
      fade_in_time   <= '0;
      fade_out_time  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_EFFECT_MODE:    effect_mode    <= cfg_data[0];
        CFG_TOTAL_DURATION: total_duration <= cfg_data[TIME_WIDTH-1:0];
        CFG_PEAK_LEVEL:     peak_level     <= cfg_data[LEVEL_WIDTH-1:0];
        CFG_FADE_IN_TIME:   fade_in_time   <= cfg_data[TIME_WIDTH-1:0];
        CFG_FADE_OUT_TIME:  fade_out_time  <= cfg_data[TIME_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      elapsed_time  <= '0;
      armed         <= 1'b0;
      current_level <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (out_load) begin
        out_level  <= current_level;
        out_active <= armed;
        out_valid  <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            if (armed) begin
              elapsed_time <= elapsed_next;
            end
            state <= ST_EVAL;
          end
        end
        ST_EVAL: begin
          if (!armed) begin
            state <= ST_OUT;
          end else if (elapsed_time >= {1'b0, total_duration}) begin
            current_level <= '0;
            armed         <= 1'b0;
            state         <= ST_OUT;
          end else if (!effect_mode) begin
            current_level <= peak_level;
            state         <= ST_OUT;
          end else if (in_fade_in) begin
            num   <= elapsed_time[TIME_WIDTH-1:0];
            den   <= fade_in_time;
            state <= ST_MUL;
          end else if (in_fade_out) begin
            num   <= remaining;
            den   <= fade_out_time;
            state <= ST_MUL;
          end else begin
            current_level <= peak_level;
            state         <= ST_OUT;
          end
        end
        ST_MUL: begin
          product <= PROD_WIDTH'(peak_level) * PROD_WIDTH'(num);
          state   <= ST_LOAD;
        end
        ST_LOAD: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            current_level <= div_quot;
            state         <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      if (cfg_hit) begin
        elapsed_time  <= '0;
        current_level <= '0;
        armed         <= 1'b1;
      end
    end
  end

  assign m_tvalid   = out_valid;
  assign m_tdata    = OUT_TDATA_WIDTH'(out_level);
  assign m_tuser[0] = out_active;

endmodule

// ===== design/hfe_checker.sv =====
// Port-level checks for the haptic fade envelope, bound to the top level.
`timescale 1ns / 1ps

module hfe_port_checks
  import hfe_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic [OUT_TDATA_WIDTH-1:0] m_tdata,
  input  logic [0:0]                 m_tuser
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result item changed while stalled");

  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[LEVEL_WIDTH-1:0] == '0)
    else $error("nonzero level on an inactive result item");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken again before the item was finished");

  a_cfg_apart: assert property (@(posedge clk) disable iff (rst)
    cfg_valid && cfg_ready |-> !(s_tvalid && s_tready))
    else $error("config write and tick item taken together");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result item shown right after reset");

endmodule

bind haptic_fade_envelope hfe_port_checks u_hfe_port_checks (.*);

// ===== dv/hfe_checker.sv =====
// Envelope checker: follows config and tick items, predicts each level item and compares it.
`timescale 1ns / 1ps

module hfe_checker
  import hfe_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [CFG_IDX_WIDTH-1:0]   cfg_index,
  input  logic [CFG_WIDTH-1:0]       cfg_data,
  input  logic                       s_tvalid,
  input  logic                       s_tready,
  input  logic [IN_TDATA_WIDTH-1:0]  s_tdata,   // [TIME_WIDTH-1:0] time_delta
  input  logic                       m_tvalid,
  input  logic                       m_tready,
  input  logic [OUT_TDATA_WIDTH-1:0] m_tdata,   // [LEVEL_WIDTH-1:0] drive_level
  input  logic [0:0]                 m_tuser,   // [0] effect_active
  output int unsigned                mismatches,
  output int unsigned                levels_due
);

  typedef struct packed {
    logic [LEVEL_WIDTH-1:0] level;
    logic                   active;
  } drive_t;

  drive_t levels_expected[$];

  logic                     fade_on;
  logic [TIME_WIDTH-1:0]    duration;
  logic [LEVEL_WIDTH-1:0]   peak;
  logic [TIME_WIDTH-1:0]    fade_in;
  logic [TIME_WIDTH-1:0]    fade_out;
  logic [ELAPSED_WIDTH-1:0] elapsed;
  logic                     armed;
  logic [LEVEL_WIDTH-1:0]   level;
  int unsigned              bad_count;
  int unsigned              levels_seen;

  function automatic logic [LEVEL_WIDTH-1:0] envelope_at(logic [ELAPSED_WIDTH-1:0] t);
    logic [PROD_WIDTH-1:0] scaled;
    logic [TIME_WIDTH-1:0] left;
    if (!fade_on) return peak;
    if (fade_in > t) begin
      scaled = PROD_WIDTH'(peak) * PROD_WIDTH'(t);
      return LEVEL_WIDTH'(scaled / fade_in);
    end
    left = duration - t[TIME_WIDTH-1:0];
    if (fade_out != '0 && fade_out >= left) begin
      scaled = PROD_WIDTH'(peak) * PROD_WIDTH'(left);
      return LEVEL_WIDTH'(scaled / fade_out);
    end
    return peak;
  endfunction

  task automatic write_register(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] value);
    case (idx)
      CFG_EFFECT_MODE:    fade_on  = value[0];
      CFG_TOTAL_DURATION: duration = value[TIME_WIDTH-1:0];
      CFG_PEAK_LEVEL:     peak     = value[LEVEL_WIDTH-1:0];
      CFG_FADE_IN_TIME:   fade_in  = value[TIME_WIDTH-1:0];
      CFG_FADE_OUT_TIME:  fade_out = value[TIME_WIDTH-1:0];
      default:            return;
    endcase
    elapsed = '0;
    level   = '0;
    armed   = 1'b1;
  endtask

  task automatic advance_tick(logic [TIME_WIDTH-1:0] delta);
    logic [ELAPSED_WIDTH:0] sum;
    if (armed) begin
      sum = {1'b0, elapsed};
      sum = sum + (ELAPSED_WIDTH + 1)'(delta);
      elapsed = (sum > ELAPSED_MAX) ? ELAPSED_MAX : sum[ELAPSED_WIDTH-1:0];
      if (elapsed < duration) begin
        level = envelope_at(elapsed);
      end else begin
        level = '0;
        armed = 1'b0;
      end
    end
    levels_expected.push_back('{level: level, active: armed});
  endtask

  task automatic count_failure(string msg);
    bad_count++;
    if (bad_count <= 10) $display("%t: %s", $realtime, msg);
  endtask

  always @(posedge clk) begin : track
    drive_t want;
    drive_t got;
    if (rst) begin
      fade_on     = 1'b0;
      duration    = DURATION_RESET;
      peak        = PEAK_RESET;
      fade_in     = '0;
      fade_out    = '0;
      elapsed     = '0;
      armed       = 1'b0;
      level       = '0;
      bad_count   = 0;
      levels_seen = 0;
      levels_expected.delete();
      mismatches <= 0;
      levels_due <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = '{level: m_tdata[LEVEL_WIDTH-1:0], active: m_tuser[0]};
        if (levels_expected.size() == 0) begin
          count_failure($sformatf("level item %0d with none expected: level %0d active %0b",
                                  levels_seen, got.level, got.active));
        end else begin
          want = levels_expected.pop_front();
          if (got.level != want.level || got.active != want.active)
            count_failure($sformatf(
              "level item %0d: expected level %0d active %0b, got level %0d active %0b",
              levels_seen, want.level, want.active, got.level, got.active));
        end
        levels_seen++;
      end
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      if (s_tvalid && s_tready) advance_tick(s_tdata[TIME_WIDTH-1:0]);
      mismatches <= bad_count;
      levels_due <= levels_expected.size();
    end
  end

endmodule

// ===== dv/tb_haptic_fade_envelope.sv =====
// Testbench top for the haptic fade envelope: clock, reset, config and tick stimulus, verdict.
`timescale 1ns / 1ps

module tb_haptic_fade_envelope;
  import hfe_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int RANDOM_TICKS = 450;
  localparam logic MODE_CONSTANT = 1'b0;
  localparam logic MODE_FADE     = 1'b1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_FIRST_UNUSED = CFG_FADE_OUT_TIME + 1'b1;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_LAST_UNUSED  = '1;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_IDX_WIDTH-1:0]   cfg_index = '0;
  logic [CFG_WIDTH-1:0]       cfg_data = '0;
  logic                       s_tvalid = 1'b0;
  logic                       s_tready;
  logic [IN_TDATA_WIDTH-1:0]  s_tdata = '0;   // [TIME_WIDTH-1:0] time_delta
  logic                       m_tvalid;
  logic                       m_tready = 1'b0;
  logic [OUT_TDATA_WIDTH-1:0] m_tdata;        // [LEVEL_WIDTH-1:0] drive_level
  logic [0:0]                 m_tuser;        // [0] effect_active
  int unsigned                mismatches;
  int unsigned                levels_due;
  int unsigned                cycle_count = 0;
  logic                       calm = 1'b0;
  logic [TIME_WIDTH-1:0]      duration_set = DURATION_RESET;

  haptic_fade_envelope u_dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  hfe_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .mismatches(mismatches), .levels_due(levels_due)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic send_tick(logic [TIME_WIDTH-1:0] delta);
    int unsigned gap;
    gap = calm ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= IN_TDATA_WIDTH'(delta);
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (levels_due != 0);
  endtask

  task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_WIDTH-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    if (idx == CFG_TOTAL_DURATION) duration_set = value[TIME_WIDTH-1:0];
    do @(posedge clk); while (!cfg_ready);
  endtask

  function automatic logic [TIME_WIDTH-1:0] pick_span(logic [TIME_WIDTH-1:0] limit);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return TIME_WIDTH'(1);
      2:       return limit;
      3:       return '1;
      4:       return TIME_WIDTH'($urandom_range(0, limit));
      default: return TIME_WIDTH'($urandom);
    endcase
  endfunction

  task automatic configure_random();
    logic [TIME_WIDTH-1:0] dur;
    int unsigned           writes;
    writes = 0;
    if ($urandom_range(0, 5) == 0)
      write_reg(CFG_IDX_WIDTH'($urandom_range(CFG_FIRST_UNUSED, CFG_LAST_UNUSED)),
                CFG_WIDTH'($urandom));
    if ($urandom_range(0, 1) == 0) begin
      write_reg(CFG_EFFECT_MODE,
                CFG_WIDTH'(($urandom_range(0, 3) == 0) ? MODE_CONSTANT : MODE_FADE));
      writes++;
    end
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 9))
        0:       dur = '0;
        1:       dur = TIME_WIDTH'(1);
        2, 3:    dur = '1;
        4, 5, 6: dur = TIME_WIDTH'($urandom_range(2, 2000));
        default: dur = TIME_WIDTH'($urandom);
      endcase
      write_reg(CFG_TOTAL_DURATION, dur);
      writes++;
    end
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 3))
        0:       write_reg(CFG_PEAK_LEVEL, '0);
        1:       write_reg(CFG_PEAK_LEVEL, '1);
        default: write_reg(CFG_PEAK_LEVEL, CFG_WIDTH'($urandom));
      endcase
      writes++;
    end
    if ($urandom_range(0, 1) == 0) begin
      write_reg(CFG_FADE_IN_TIME, pick_span(duration_set));
      writes++;
    end
    if (writes == 0 || $urandom_range(0, 1) == 0)
      write_reg(CFG_FADE_OUT_TIME, pick_span(duration_set));
    cfg_valid <= 1'b0;
  endtask

  initial begin : sink
    int unsigned stall;
    while (rst) @(posedge clk);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 4);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_haptic_fade_envelope NOT OK");
    $finish;
  end

  initial begin : stimulus
    int unsigned sent;
    int unsigned count;
    int unsigned reach;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // idle after reset, then writes to unused indexes that must not arm
    send_tick('0);
    send_tick('1);
    wait_drain();
    write_reg(CFG_FIRST_UNUSED, '1);
    write_reg(CFG_LAST_UNUSED, '0);
    cfg_valid <= 1'b0;
    send_tick(TIME_WIDTH'(7));
    send_tick('1);
    wait_drain();

    // constant level with reset duration and peak, run to the end and one tick past
    write_reg(CFG_EFFECT_MODE, CFG_WIDTH'(MODE_CONSTANT));
    cfg_valid <= 1'b0;
    send_tick('0);
    send_tick(TIME_WIDTH'(500));
    send_tick(TIME_WIDTH'(499));
    send_tick(TIME_WIDTH'(1));
    send_tick(TIME_WIDTH'(3));
    wait_drain();

    // zero duration ends on the first tick
    write_reg(CFG_TOTAL_DURATION, '0);
    cfg_valid <= 1'b0;
    send_tick('0);
    send_tick(TIME_WIDTH'(5));
    wait_drain();

    // fade-in, plateau, fade-out down to one unit left, then the end of the effect
    write_reg(CFG_EFFECT_MODE, CFG_WIDTH'(MODE_FADE));
    write_reg(CFG_TOTAL_DURATION, TIME_WIDTH'(1000));
    write_reg(CFG_PEAK_LEVEL, LEVEL_WIDTH'(40000));
    write_reg(CFG_FADE_IN_TIME, TIME_WIDTH'(200));
    write_reg(CFG_FADE_OUT_TIME, TIME_WIDTH'(300));
    cfg_valid <= 1'b0;
    send_tick('0);
    send_tick(TIME_WIDTH'(100));
    send_tick(TIME_WIDTH'(150));
    send_tick(TIME_WIDTH'(500));
    send_tick(TIME_WIDTH'(249));
    send_tick(TIME_WIDTH'(1));
    wait_drain();

    // full-scale ramps overlapping over the whole effect
    write_reg(CFG_TOTAL_DURATION, '1);
    write_reg(CFG_PEAK_LEVEL, '1);
    write_reg(CFG_FADE_IN_TIME, '1);
    write_reg(CFG_FADE_OUT_TIME, '1);
    cfg_valid <= 1'b0;
    send_tick(TIME_WIDTH'(1));
    send_tick(TIME_WIDTH'(32767));
    send_tick(TIME_WIDTH'(32766));
    send_tick(TIME_WIDTH'(1));
    wait_drain();

    sent = 0;
    while (sent < RANDOM_TICKS) begin
      calm = ($urandom_range(0, 3) == 0);
      configure_random();
      count = $urandom_range(4, 40);
      reach = 2 * duration_set / count + 1;
      for (int i = 0; i < count; i++) begin
        if (i == count / 2 && $urandom_range(0, 5) == 0) wait_drain();
        case ($urandom_range(0, 9))
          0:       send_tick(TIME_WIDTH'($urandom));
          1:       send_tick('0);
          default: send_tick(TIME_WIDTH'($urandom_range(0, reach)));
        endcase
        sent++;
      end
      wait_drain();
    end

    repeat (30) @(posedge clk);
    if (mismatches == 0 && levels_due == 0) begin
      $display("tb_haptic_fade_envelope OK");
    end else begin
      $display("tb_haptic_fade_envelope NOT OK");
    end
    $finish;
  end

endmodule
